// File: design/echo_tracking_score_accumulator_unit_assert.svh
// Assertion macros shared by the checking code of the accumulator.
`ifndef ECHO_TRACKING_SCORE_ACCUMULATOR_UNIT_ASSERT_SVH
`define ECHO_TRACKING_SCORE_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ETSA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define ETSA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/etsa_pkg.sv
package etsa_pkg;

  // Default sizes of the accumulators
  localparam int COUNT_BITS_DEF = 24;
  localparam int SUM_BITS_DEF   = 56;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int HGT_W     = 16;
  localparam int REAL_W    = 15;
  localparam int N_W       = 24;
  localparam int TOL_W     = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_OUT_W = 24;
  localparam int RATE_W    = 17;
  localparam int RATE_FRAC = 16;
  localparam int Q_ONE     = 65536;
  localparam int RMSE_W    = 23;
  localparam int RMSE_MAX  = 8388607;

  // Internal widths
  localparam int ERR_W      = 16;
  localparam int SQ_W       = 2 * ERR_W;
  localparam int COL_W      = 12;
  localparam int DIST_W     = 13;
  localparam int X_W        = 46;
  localparam int SQRT_STEPS = X_W / 2;
  localparam int QUEUE_DEPTH = 2;

  // Column math: height / 10 as a multiply by reciprocal
  localparam int COL_MUL   = 52429;
  localparam int COL_SHIFT = 19;

  // Overlap: zero at a column distance of OVLP_SPAN, a hit up to OVLP_HIT
  localparam int OVLP_SPAN = 50;
  localparam int OVLP_HIT  = 20;
  localparam int OV_IDX_W  = 6;
  localparam int OV_TAB_N  = 1 << OV_IDX_W;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 1'b1;
  localparam logic [TOL_W-1:0] NEAR_TOL_RST = 15'd30;
  localparam logic [TOL_W-1:0] FAR_TOL_RST  = 15'd200;

  // Estimate code for a lost echo
  localparam logic [HGT_W-1:0] LOST_CODE = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Classified request between front and back
  typedef struct packed {
    cmd_e               kind;
    logic [RATE_W-1:0]  overlap;
    logic               lost;
    logic               near_hit;
    logic               far_hit;
    logic               ovl_hit;
    logic [ERR_W-1:0]   abs_err;
    logic [N_W-1:0]     n;
  } op_t;

  // One result item
  typedef struct packed {
    logic [RATE_W-1:0]    overlap_rate;
    logic [CNT_OUT_W-1:0] lost_count;
    logic [CNT_OUT_W-1:0] near_count;
    logic [CNT_OUT_W-1:0] overlap_count;
    logic [CNT_OUT_W-1:0] far_count;
    logic [RATE_W-1:0]    echo_rate;
    logic [RATE_W-1:0]    height_rate;
    logic [RATE_W-1:0]    lost_rate;
    logic [RMSE_W-1:0]    rmse;
    logic                 status;
  } res_t;

  // Control to the iterative divide / root unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } rpt_req_t;

  typedef logic [OV_TAB_N-1:0][RATE_W-1:0] ov_tab_t;

  // Overlap in Q1.16 for each column distance, zero from OVLP_SPAN up
  function automatic ov_tab_t ov_table();
    ov_tab_t t;
    t = '0;
    for (int i = 0; i < OVLP_SPAN; i++) begin
      t[i] = RATE_W'(((OVLP_SPAN - i) * Q_ONE) / OVLP_SPAN);
    end
    return t;
  endfunction

  localparam ov_tab_t OV_TAB = ov_table();

  // Dividend width of the shared divider
  function automatic int dvd_width(int count_bits, int sum_bits);
    return ((sum_bits > count_bits) ? sum_bits : count_bits) + RATE_FRAC;
  endfunction

endpackage

// File: design/etsa_front.sv
module etsa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [etsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etsa_pkg::TOL_W-1:0]       cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [etsa_pkg::CMD_W-1:0]       cmd,
  input  logic signed [etsa_pkg::HGT_W-1:0] eva_height,
  input  logic [etsa_pkg::REAL_W-1:0]      real_height,
  input  logic [etsa_pkg::N_W-1:0]         sample_count,
  output logic                             q_push,
  output etsa_pkg::op_t                    q_data,
  input  logic                             q_full
);
  import etsa_pkg::*;

  localparam int PROD_W = 2 * HGT_W;

  logic [TOL_W-1:0] near_tol, far_tol;

  // Stage 1: captured request
  logic               s1_v;
  logic [CMD_W-1:0]   s1_cmd;
  logic [HGT_W-1:0]   s1_eva;
  logic [REAL_W-1:0]  s1_real;
  logic [N_W-1:0]     s1_n;

  // Stage 2: columns and error
  logic               s2_v;
  logic [CMD_W-1:0]   s2_cmd;
  logic               s2_eva_neg;
  logic [COL_W-1:0]   s2_qe, s2_qr;
  logic [ERR_W-1:0]   s2_abs;
  logic               s2_lost;
  logic [N_W-1:0]     s2_n;

  logic               s1_ready, s2_ready;
  logic [HGT_W-1:0]   eva_mag;
  logic [PROD_W-1:0]  prod_e, prod_r;
  logic [COL_W-1:0]   qe, qr;
  logic signed [ERR_W:0] err;
  logic [ERR_W-1:0]   abs_err;
  logic [DIST_W-1:0]  col_dist;

  assign s2_ready = !s2_v || !q_full;
  assign s1_ready = !s1_v || s2_ready;
  assign full     = !s1_ready;

  // Column = height / 10, truncated toward zero on the magnitude
  always_comb begin
    eva_mag = s1_eva[HGT_W-1] ? (~s1_eva + 1'b1) : s1_eva;
    prod_e  = PROD_W'(eva_mag) * PROD_W'(COL_MUL);
    prod_r  = PROD_W'(s1_real) * PROD_W'(COL_MUL);
    qe      = COL_W'(prod_e >> COL_SHIFT);
    qr      = COL_W'(prod_r >> COL_SHIFT);
    err     = $signed({2'b00, s1_real}) - $signed({s1_eva[HGT_W-1], s1_eva});
    abs_err = err[ERR_W] ? ERR_W'(-err) : ERR_W'(err);
  end

  // Column distance; a negative estimate sits left of every real column
  always_comb begin
    if (s2_eva_neg) begin
      col_dist = DIST_W'(s2_qe) + DIST_W'(s2_qr);
    end else if (s2_qe >= s2_qr) begin
      col_dist = DIST_W'(s2_qe - s2_qr);
    end else begin
      col_dist = DIST_W'(s2_qr - s2_qe);
    end
  end

  // Classified request
  always_comb begin
    q_data.kind     = cmd_e'(s2_cmd);
    q_data.overlap  = (col_dist[DIST_W-1:OV_IDX_W] == '0) ?
                      OV_TAB[col_dist[OV_IDX_W-1:0]] : '0;
    q_data.lost     = s2_lost;
    q_data.near_hit = s2_abs < ERR_W'(near_tol);
    q_data.far_hit  = s2_abs <= ERR_W'(far_tol);
    q_data.ovl_hit  = col_dist <= DIST_W'(OVLP_HIT);
    q_data.abs_err  = s2_abs;
    q_data.n        = s2_n;
  end

  assign q_push = s2_v && !q_full;

  // Control and tolerance registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      near_tol <= NEAR_TOL_RST;
      far_tol  <= FAR_TOL_RST;
    end else begin
      if (s1_ready) begin
        s1_v <= push;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (cfg_write && cfg_index == REG_NEAR) begin
        near_tol <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_FAR) begin
        far_tol <= cfg_data;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push && s1_ready) begin
      s1_cmd  <= cmd;
      s1_eva  <= eva_height;
      s1_real <= real_height;
      s1_n    <= sample_count;
    end
    if (s1_v && s2_ready) begin
      s2_cmd     <= s1_cmd;
      s2_eva_neg <= s1_eva[HGT_W-1];
      s2_qe      <= qe;
      s2_qr      <= qr;
      s2_abs     <= abs_err;
      s2_lost    <= (s1_eva == LOST_CODE);
      s2_n       <= s1_n;
    end
  end

endmodule

// File: design/etsa_fifo.sv
module etsa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  etsa_pkg::op_t wdata,
  output logic          full,
  input  logic          pop,
  output etsa_pkg::op_t rdata,
  output logic          empty
);
  import etsa_pkg::*;

  // Depth is a power of two, so the pointers wrap by themselves
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign full    = (cnt == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= wdata;
    end
  end

endmodule

// File: design/etsa_iter.sv
module etsa_iter #(
  parameter int DVD_W = etsa_pkg::dvd_width(etsa_pkg::COUNT_BITS_DEF, etsa_pkg::SUM_BITS_DEF)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  etsa_pkg::rpt_req_t           req,
  input  logic [DVD_W-1:0]             operand,
  input  logic [etsa_pkg::N_W-1:0]     divisor,
  output logic                         done,
  output logic [DVD_W-1:0]             quot,
  output logic [etsa_pkg::RMSE_W-1:0]  root
);
  import etsa_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy, sqrt_mode;
  logic [STEP_W-1:0] cnt;

  // Divider: dividend shifts out at the top, quotient bits enter below
  logic [DVD_W-1:0]  acc;
  logic [N_W-1:0]    rem, dsr;
  logic [N_W:0]      sh, diff;
  logic              dge;

  // Root: digit by digit, two bits of the operand per step
  logic [X_W-1:0]    xr, rt, bt;
  logic [X_W:0]      trial;
  logic              sge;

  always_comb begin
    sh    = {rem, acc[DVD_W-1]};
    diff  = sh - {1'b0, dsr};
    dge   = !diff[N_W];
    trial = {1'b0, rt} + {1'b0, bt};
    sge   = {1'b0, xr} >= trial;
  end

  assign quot = acc;
  assign root = rt[RMSE_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.sqrt_mode ? STEP_W'(SQRT_STEPS) : STEP_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_mode <= req.sqrt_mode;
      acc       <= operand;
      rem       <= '0;
      dsr       <= divisor;
      xr        <= operand[X_W-1:0];
      rt        <= '0;
      bt        <= X_W'(1) << (X_W - 2);
    end else if (busy) begin
      if (sqrt_mode) begin
        xr <= sge ? X_W'({1'b0, xr} - trial) : xr;
        rt <= sge ? (rt >> 1) + bt : rt >> 1;
        bt <= bt >> 2;
      end else begin
        rem <= dge ? diff[N_W-1:0] : sh[N_W-1:0];
        acc <= {acc[DVD_W-2:0], dge};
      end
    end
  end

endmodule

// File: design/etsa_back.sv
module etsa_back #(
  parameter int COUNT_BITS = etsa_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS   = etsa_pkg::SUM_BITS_DEF,
  parameter int DVD_W      = etsa_pkg::dvd_width(COUNT_BITS, SUM_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  etsa_pkg::op_t                q_data,
  output logic                         q_pop,
  output etsa_pkg::rpt_req_t           rpt_req,
  output logic [DVD_W-1:0]             rpt_operand,
  output logic [etsa_pkg::N_W-1:0]     rpt_divisor,
  input  logic                         rpt_done,
  input  logic [DVD_W-1:0]             rpt_quot,
  input  logic [etsa_pkg::RMSE_W-1:0]  rpt_root,
  input  logic                         pop,
  output logic                         empty,
  output etsa_pkg::res_t               res
);
  import etsa_pkg::*;

  localparam int CW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam int NUM_RATES = 3;
  localparam logic [1:0] RATE_ECHO   = 2'd0;
  localparam logic [1:0] RATE_HEIGHT = 2'd1;
  localparam logic [1:0] RATE_LOST   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_ERR_GO,
    ST_ERR_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT
  } state_t;

  state_t state, state_next;
  op_t    cur;
  logic [SQ_W-1:0] sq;

  logic [COUNT_BITS-1:0] lost_tot, near_tot, ovl_tot, far_tot;
  logic [COUNT_BITS-1:0] lost_next, near_next, ovl_next, far_next;
  logic [SUM_BITS-1:0]   sum, sum_next;
  logic [1:0]            rate_idx, rate_idx_next;
  logic [RATE_W-1:0]     rate_q [NUM_RATES];
  logic [RATE_W-1:0]     rate_next [NUM_RATES];
  logic                  out_v, out_v_next;
  res_t                  res_next;

  logic                  take, emit, e_rep, e_status;
  logic [RATE_W-1:0]     e_ov;
  logic [RMSE_W-1:0]     e_rmse;
  logic [COUNT_BITS-1:0] rate_cnt;
  logic [CW-1:0]         n_w, lost_w, cnt_w;
  logic [SUM_BITS:0]     sum_add;
  logic [RATE_W-1:0]     rate_val;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_view(logic [COUNT_BITS-1:0] c);
    logic [CW-1:0] w;
    w = CW'(c);
    return w[CNT_OUT_W-1:0];
  endfunction

  assign empty = !out_v;
  assign take  = (state == ST_IDLE) && !q_empty && (!out_v || pop);
  assign q_pop = take;

  // Count that feeds the current rate
  always_comb begin
    unique case (rate_idx)
      RATE_ECHO:   rate_cnt = ovl_tot;
      RATE_HEIGHT: rate_cnt = near_tot;
      RATE_LOST:   rate_cnt = lost_tot;
      default:     rate_cnt = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    lost_next     = lost_tot;
    near_next     = near_tot;
    ovl_next      = ovl_tot;
    far_next      = far_tot;
    sum_next      = sum;
    rate_idx_next = rate_idx;
    rate_next     = rate_q;
    emit          = 1'b0;
    e_rep         = 1'b0;
    e_status      = 1'b0;
    e_ov          = '0;
    e_rmse        = '0;
    rpt_req       = '0;
    rpt_operand   = '0;
    rpt_divisor   = cur.n;
    n_w           = CW'(cur.n);
    lost_w        = CW'(lost_tot);
    cnt_w         = CW'(rate_cnt);
    rate_val      = (cnt_w >= n_w) ? RATE_W'(Q_ONE) : rpt_quot[RATE_W-1:0];
    sum_add       = (SUM_BITS + 1)'(sum) + (SUM_BITS + 1)'(sq);

    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (q_data.kind)
            CMD_SAMPLE: state_next = ST_SQUARE;
            CMD_CLEAR: begin
              lost_next = '0;
              near_next = '0;
              ovl_next  = '0;
              far_next  = '0;
              sum_next  = '0;
              emit      = 1'b1;
            end
            CMD_REPORT: begin
              if (q_data.n == '0) begin
                emit     = 1'b1;
                e_status = 1'b1;
              end else begin
                rate_idx_next = RATE_ECHO;
                state_next    = ST_RATE_GO;
              end
            end
            CMD_NONE: emit = 1'b1;
          endcase
        end
      end
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (cur.lost) begin
          lost_next = sat_inc(lost_tot);
        end else begin
          sum_next = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
          if (cur.near_hit) near_next = sat_inc(near_tot);
          if (cur.ovl_hit)  ovl_next  = sat_inc(ovl_tot);
          if (cur.far_hit)  far_next  = sat_inc(far_tot);
        end
        emit       = 1'b1;
        e_ov       = cur.overlap;
        state_next = ST_IDLE;
      end
      ST_RATE_GO: begin
        rpt_req.start = 1'b1;
        rpt_operand   = DVD_W'(rate_cnt) << RATE_FRAC;
        state_next    = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (rpt_done) begin
          rate_next[rate_idx] = rate_val;
          if (rate_idx == RATE_LOST) begin
            if (n_w <= lost_w) begin
              // no sample left for the error average
              emit       = 1'b1;
              e_rep      = 1'b1;
              e_status   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_ERR_GO;
            end
          end else begin
            rate_idx_next = rate_idx + 1'b1;
            state_next    = ST_RATE_GO;
          end
        end
      end
      ST_ERR_GO: begin
        rpt_req.start = 1'b1;
        rpt_operand   = DVD_W'(sum) << RATE_FRAC;
        rpt_divisor   = N_W'(n_w - lost_w);
        state_next    = ST_ERR_WAIT;
      end
      ST_ERR_WAIT: begin
        if (rpt_done) begin
          if (|rpt_quot[DVD_W-1:X_W]) begin
            // mean square error beyond the root range
            emit       = 1'b1;
            e_rep      = 1'b1;
            e_rmse     = RMSE_W'(RMSE_MAX);
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ROOT_GO;
          end
        end
      end
      ST_ROOT_GO: begin
        rpt_req.start     = 1'b1;
        rpt_req.sqrt_mode = 1'b1;
        rpt_operand       = rpt_quot;
        state_next        = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (rpt_done) begin
          emit       = 1'b1;
          e_rep      = 1'b1;
          e_rmse     = rpt_root;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result assembly
  always_comb begin
    res_next = res;
    if (emit) begin
      res_next.overlap_rate  = e_ov;
      res_next.lost_count    = cnt_view(lost_next);
      res_next.near_count    = cnt_view(near_next);
      res_next.overlap_count = cnt_view(ovl_next);
      res_next.far_count     = cnt_view(far_next);
      res_next.echo_rate     = e_rep ? rate_next[RATE_ECHO] : '0;
      res_next.height_rate   = e_rep ? rate_next[RATE_HEIGHT] : '0;
      res_next.lost_rate     = e_rep ? rate_next[RATE_LOST] : '0;
      res_next.rmse          = e_rmse;
      res_next.status        = e_status;
    end
    if (emit) begin
      out_v_next = 1'b1;
    end else if (pop && out_v) begin
      out_v_next = 1'b0;
    end else begin
      out_v_next = out_v;
    end
  end

  // State, accumulators and the result register
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
    sq     <= cur.abs_err * cur.abs_err;
    rate_q <= rate_next;
    res    <= res_next;
    if (rst) begin
      state    <= ST_IDLE;
      out_v    <= 1'b0;
      lost_tot <= '0;
      near_tot <= '0;
      ovl_tot  <= '0;
      far_tot  <= '0;
      sum      <= '0;
      rate_idx <= '0;
    end else begin
      state    <= state_next;
      out_v    <= out_v_next;
      lost_tot <= lost_next;
      near_tot <= near_next;
      ovl_tot  <= ovl_next;
      far_tot  <= far_next;
      sum      <= sum_next;
      rate_idx <= rate_idx_next;
    end
  end

endmodule

// File: design/echo_tracking_score_accumulator_unit.sv
// Echo tracking score accumulator. Requests enter through a queue-style port
// (push/full) and each gives exactly one result (empty/pop). A two-stage
// front computes the box overlap and the error classes and hands them to the
// back through a two-entry queue. In the back a sample passes take, square,
// then accumulate and write the result; a clear or unused command ends at
// take. A report runs up to three rate divisions and one error division
// through a shared restoring divider, one quotient bit per cycle, and a
// 23-step square root, DVD_W = max(SUM_BITS, COUNT_BITS) + 16. A finished
// result waits in an output register, so the back starts the next request as
// soon as it is popped. Tolerances are written through cfg_write/cfg_index/
// cfg_data; the user must do so only while idle, the block does not enforce it.
`include "echo_tracking_score_accumulator_unit_assert.svh"

module echo_tracking_score_accumulator_unit #(
  parameter int COUNT_BITS = etsa_pkg::COUNT_BITS_DEF,
  parameter int SUM_BITS   = etsa_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [etsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [etsa_pkg::TOL_W-1:0]        cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [etsa_pkg::CMD_W-1:0]        cmd,
  input  logic signed [etsa_pkg::HGT_W-1:0] eva_height,
  input  logic [etsa_pkg::REAL_W-1:0]       real_height,
  input  logic [etsa_pkg::N_W-1:0]          sample_count,
  input  logic                              pop,
  output logic                              empty,
  output logic [etsa_pkg::RATE_W-1:0]       overlap_rate,
  output logic [etsa_pkg::CNT_OUT_W-1:0]    lost_count,
  output logic [etsa_pkg::CNT_OUT_W-1:0]    near_count,
  output logic [etsa_pkg::CNT_OUT_W-1:0]    overlap_count,
  output logic [etsa_pkg::CNT_OUT_W-1:0]    far_count,
  output logic [etsa_pkg::RATE_W-1:0]       echo_rate,
  output logic [etsa_pkg::RATE_W-1:0]       height_rate,
  output logic [etsa_pkg::RATE_W-1:0]       lost_rate,
  output logic [etsa_pkg::RMSE_W-1:0]       rmse,
  output logic                              status
);
  import etsa_pkg::*;

  localparam int DVD_W = dvd_width(COUNT_BITS, SUM_BITS);

  logic             q_push, q_full, q_pop, q_empty;
  op_t              q_in, q_head;
  rpt_req_t         rpt_req;
  logic [DVD_W-1:0] rpt_operand, rpt_quot;
  logic [N_W-1:0]   rpt_divisor;
  logic             rpt_done;
  logic [RMSE_W-1:0] rpt_root;
  res_t             res;

  etsa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .eva_height   (eva_height),
    .real_height  (real_height),
    .sample_count (sample_count),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  etsa_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  etsa_iter #(
    .DVD_W (DVD_W)
  ) u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (rpt_req),
    .operand (rpt_operand),
    .divisor (rpt_divisor),
    .done    (rpt_done),
    .quot    (rpt_quot),
    .root    (rpt_root)
  );

  etsa_back #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS),
    .DVD_W      (DVD_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .rpt_req     (rpt_req),
    .rpt_operand (rpt_operand),
    .rpt_divisor (rpt_divisor),
    .rpt_done    (rpt_done),
    .rpt_quot    (rpt_quot),
    .rpt_root    (rpt_root),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  // Result fields
  assign overlap_rate  = res.overlap_rate;
  assign lost_count    = res.lost_count;
  assign near_count    = res.near_count;
  assign overlap_count = res.overlap_count;
  assign far_count     = res.far_count;
  assign echo_rate     = res.echo_rate;
  assign height_rate   = res.height_rate;
  assign lost_rate     = res.lost_rate;
  assign rmse          = res.rmse;
  assign status        = res.status;

  // Checks
  `ETSA_CHECK(a_status_zero_rmse, !empty && status, rmse == '0, "rmse set on a failed report")
  `ETSA_CHECK(a_sample_no_report, !empty && overlap_rate != '0, status == 1'b0 && rmse == '0 && echo_rate == '0, "sample result carries report fields")
  `ETSA_CHECK(a_rate_range, !empty, echo_rate <= RATE_W'(Q_ONE) && height_rate <= RATE_W'(Q_ONE) && lost_rate <= RATE_W'(Q_ONE), "rate above one")
  `ETSA_CHECK_NEXT(a_queue_fill, q_push && !q_pop, !q_empty, "queue lost a request")

endmodule

// File: test/echo_tracking_score_accumulator_unit_tb.sv
module echo_tracking_score_accumulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etsa_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int ACC_W = SUM_BITS_DEF;
  localparam int N_PHASES = 5;
  localparam int PHASE_ITEMS = 240;

  // Expected-result tracker: mirrors tolerances and accumulators, holds the
  // results still owed by the block in arrival order.
  class score_board;
    bit [TOL_W-1:0] near_tol;
    bit [TOL_W-1:0] far_tol;
    bit [CNT_W-1:0] lost_total;
    bit [CNT_W-1:0] near_total;
    bit [CNT_W-1:0] ovl_total;
    bit [CNT_W-1:0] far_total;
    bit [ACC_W-1:0] sq_err_sum;
    res_t           owed_q[$];
    int             mismatches;
    int             checked;

    function new();
      near_tol = NEAR_TOL_RST;
      far_tol = FAR_TOL_RST;
      mismatches = 0;
      checked = 0;
      clear_totals();
    endfunction

    function void clear_totals();
      lost_total = '0;
      near_total = '0;
      ovl_total = '0;
      far_total = '0;
      sq_err_sum = '0;
    endfunction

    // Saturating counter step
    function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function bit [RATE_W-1:0] q16_rate(bit [CNT_W-1:0] cnt, bit [N_W-1:0] n);
      longint unsigned q;
      q = (longint'(cnt) * longint'(Q_ONE)) / longint'(n);
      return (q > Q_ONE) ? RATE_W'(Q_ONE) : RATE_W'(q);
    endfunction

    // Bitwise integer square root, floor
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Accepted request: update the mirrored state, queue the expected result
    function void note_request(logic [CMD_W-1:0] c, logic signed [HGT_W-1:0] eva,
                               logic [REAL_W-1:0] rh, logic [N_W-1:0] n);
      res_t r;
      int eva_i;
      int rh_i;
      int col_d;
      int err;
      longint unsigned abs_e;
      longint unsigned sq;
      longint unsigned sum_max;
      longint unsigned m;
      longint unsigned q;
      longint unsigned x;
      longint unsigned root;
      r = '0;
      sum_max = (64'd1 << ACC_W) - 1;
      case (c)
        CMD_SAMPLE: begin
          eva_i = eva;
          rh_i = int'(rh);
          col_d = eva_i / 10 - rh_i / 10;
          if (col_d < 0) col_d = -col_d;
          if (col_d < OVLP_SPAN)
            r.overlap_rate = RATE_W'(((OVLP_SPAN - col_d) * Q_ONE) / OVLP_SPAN);
          if (eva == LOST_CODE) begin
            lost_total = bump(lost_total);
          end else begin
            err = rh_i - eva_i;
            abs_e = (err < 0) ? longint'(-err) : longint'(err);
            sq = abs_e * abs_e;
            if (sq > sum_max - sq_err_sum) sq_err_sum = sum_max;
            else sq_err_sum = sq_err_sum + sq;
            if (abs_e < near_tol) near_total = bump(near_total);
            if (col_d <= OVLP_HIT) ovl_total = bump(ovl_total);
            if (abs_e <= far_tol) far_total = bump(far_total);
          end
        end
        CMD_CLEAR: clear_totals();
        CMD_REPORT: begin
          if (n == 0) begin
            r.status = 1'b1;
          end else begin
            r.echo_rate = q16_rate(ovl_total, n);
            r.height_rate = q16_rate(near_total, n);
            r.lost_rate = q16_rate(lost_total, n);
            if (n <= lost_total) begin
              r.status = 1'b1;
            end else begin
              m = longint'(n) - longint'(lost_total);
              q = sq_err_sum / m;
              if (q >= (64'd1 << 30)) begin
                r.rmse = RMSE_W'(RMSE_MAX);
              end else begin
                x = q * Q_ONE + ((sq_err_sum % m) * Q_ONE) / m;
                root = int_sqrt(x);
                r.rmse = (root > RMSE_MAX) ? RMSE_W'(RMSE_MAX) : RMSE_W'(root);
              end
            end
          end
        end
        default: ;
      endcase
      r.lost_count = lost_total;
      r.near_count = near_total;
      r.overlap_count = ovl_total;
      r.far_count = far_total;
      owed_q.push_back(r);
    endfunction

    function void field_cmp(string name, longint unsigned want, longint unsigned got);
      if (want == got) return;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request pending", $realtime);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      field_cmp("overlap_rate", want.overlap_rate, got.overlap_rate);
      field_cmp("lost_count", want.lost_count, got.lost_count);
      field_cmp("near_count", want.near_count, got.near_count);
      field_cmp("overlap_count", want.overlap_count, got.overlap_count);
      field_cmp("far_count", want.far_count, got.far_count);
      field_cmp("echo_rate", want.echo_rate, got.echo_rate);
      field_cmp("height_rate", want.height_rate, got.height_rate);
      field_cmp("lost_rate", want.lost_rate, got.lost_rate);
      field_cmp("rmse", want.rmse, got.rmse);
      field_cmp("status", want.status, got.status);
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [TOL_W-1:0]         cfg_data;
  logic                     push;
  logic                     full;
  logic [CMD_W-1:0]         cmd;
  logic signed [HGT_W-1:0]  eva_height;
  logic [REAL_W-1:0]        real_height;
  logic [N_W-1:0]           sample_count;
  logic                     pop;
  logic                     empty;
  logic [RATE_W-1:0]        overlap_rate;
  logic [CNT_OUT_W-1:0]     lost_count;
  logic [CNT_OUT_W-1:0]     near_count;
  logic [CNT_OUT_W-1:0]     overlap_count;
  logic [CNT_OUT_W-1:0]     far_count;
  logic [RATE_W-1:0]        echo_rate;
  logic [RATE_W-1:0]        height_rate;
  logic [RATE_W-1:0]        lost_rate;
  logic [RMSE_W-1:0]        rmse;
  logic                     status;

  score_board sb;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int gen_samples;
  int gen_lost;
  int n_sample;
  int n_lost;
  int n_clear;
  int n_report;
  int n_unused;

  echo_tracking_score_accumulator_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .cmd(cmd),
    .eva_height(eva_height),
    .real_height(real_height),
    .sample_count(sample_count),
    .pop(pop),
    .empty(empty),
    .overlap_rate(overlap_rate),
    .lost_count(lost_count),
    .near_count(near_count),
    .overlap_count(overlap_count),
    .far_count(far_count),
    .echo_rate(echo_rate),
    .height_rate(height_rate),
    .lost_rate(lost_rate),
    .rmse(rmse),
    .status(status)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Request monitor
  always @(posedge clk) begin
    if (!rst && push && !full)
      sb.note_request(cmd, eva_height, real_height, sample_count);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result('{overlap_rate, lost_count, near_count, overlap_count, far_count,
                        echo_rate, height_rate, lost_rate, rmse, status});
  end

  // Result consumer: random stalls, plus a long hold-off when asked
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        pop <= 1'b0;
        hold_req--;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_NEAR) sb.near_tol = val;
    else sb.far_tol = val;
    @(posedge clk);
  endtask

  task automatic set_tolerances(logic [TOL_W-1:0] near_v, logic [TOL_W-1:0] far_v);
    write_reg(REG_NEAR, near_v);
    write_reg(REG_FAR, far_v);
  endtask

  // Offer one request after a random gap, hold it until taken
  task automatic send_item(cmd_e c, logic signed [HGT_W-1:0] e, logic [REAL_W-1:0] rh,
                           logic [N_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    eva_height <= e;
    real_height <= rh;
    sample_count <= n;
    @(posedge clk);
    while (full) @(posedge clk);
    case (c)
      CMD_SAMPLE: begin
        n_sample++;
        gen_samples++;
        if (e == LOST_CODE) begin
          n_lost++;
          gen_lost++;
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        gen_samples = 0;
        gen_lost = 0;
      end
      CMD_REPORT: n_report++;
      default: n_unused++;
    endcase
  endtask

  // Wait until every owed result has been taken; the first edge lets the
  // request monitor log the last accepted request
  task automatic drain();
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly realistic samples near the truth, some lost, some noise
  task automatic random_sample();
    logic [REAL_W-1:0] rh;
    int sel;
    int span;
    int e;
    rh = ($urandom_range(99) < 20) ? REAL_W'($urandom_range(99)) : REAL_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 12) begin
      send_item(CMD_SAMPLE, LOST_CODE, rh, N_W'($urandom));
    end else if (sel < 20) begin
      send_item(CMD_SAMPLE, HGT_W'($urandom), rh, N_W'($urandom));
    end else begin
      case ($urandom_range(2))
        0: span = 40;
        1: span = 300;
        default: span = 600;
      endcase
      e = int'(rh) + $urandom_range(2 * span) - span;
      if (e > 32767) e = 32767;
      send_item(CMD_SAMPLE, HGT_W'(e), rh, N_W'($urandom));
    end
  endtask

  task automatic random_item();
    int sel;
    int ns;
    logic [N_W-1:0] n;
    sel = $urandom_range(99);
    if (sel < 80) begin
      random_sample();
    end else if (sel < 82) begin
      send_item(CMD_CLEAR, HGT_W'($urandom), REAL_W'($urandom), N_W'($urandom));
    end else if (sel < 84) begin
      send_item(CMD_NONE, HGT_W'($urandom), REAL_W'($urandom), N_W'($urandom));
    end else begin
      ns = $urandom_range(99);
      if (ns < 55) n = N_W'(gen_samples);
      else if (ns < 65) n = N_W'(gen_lost);
      else if (ns < 72) n = '0;
      else if (ns < 85) n = N_W'($urandom_range(8, 1));
      else n = N_W'($urandom);
      send_item(CMD_REPORT, HGT_W'($urandom), REAL_W'($urandom), n);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    gen_samples = 0;
    gen_lost = 0;
    n_sample = 0;
    n_lost = 0;
    n_clear = 0;
    n_report = 0;
    n_unused = 0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_NEAR;
    cfg_data <= '0;
    push <= 1'b0;
    cmd <= CMD_SAMPLE;
    eva_height <= '0;
    real_height <= '0;
    sample_count <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset tolerances (near 30, far 200)
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd0);            // zero divisor
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd5);            // empty sums
    send_item(CMD_SAMPLE, LOST_CODE, 15'd0, 24'd0);          // lost, full overlap
    send_item(CMD_SAMPLE, LOST_CODE, 15'd32767, 24'hFFFFFF); // lost, no overlap
    send_item(CMD_SAMPLE, -16'sd32768, 15'd32767, 24'd0);   // largest error
    send_item(CMD_SAMPLE, 16'sd32767, 15'd0, 24'd0);
    send_item(CMD_SAMPLE, -16'sd15, 15'd5, 24'd0);          // negative estimate
    send_item(CMD_SAMPLE, 16'sd129, 15'd100, 24'd0);        // error just inside near
    send_item(CMD_SAMPLE, 16'sd130, 15'd100, 24'd0);        // error at near
    send_item(CMD_SAMPLE, 16'sd1200, 15'd1000, 24'd0);      // far edge, 20 columns
    send_item(CMD_SAMPLE, 16'sd1201, 15'd1000, 24'd0);      // just past far
    send_item(CMD_SAMPLE, 16'sd1210, 15'd1000, 24'd0);      // 21 columns
    send_item(CMD_SAMPLE, 16'sd1490, 15'd1000, 24'd0);      // 49 columns
    send_item(CMD_SAMPLE, 16'sd1500, 15'd1000, 24'd0);      // 50 columns
    send_item(CMD_SAMPLE, 16'sd0, 15'd0, 24'd0);            // exact
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd1);            // all lost, rates saturate
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd3);            // one kept sample, rmse clips
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'hFFFFFF);       // largest divisor
    send_item(CMD_NONE, -16'sd1, 15'd32767, 24'hFFFFFF);    // unused command
    send_item(CMD_CLEAR, 16'sd0, 15'd0, 24'd0);
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd4);            // after clear
    send_item(CMD_SAMPLE, 16'sd32767, 15'd32767, 24'd0);
    send_item(CMD_REPORT, 16'sd0, 15'd0, 24'd1);
    push <= 1'b0;
    drain();

    // Random phases, each with its own tolerances and flow-control mix
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          set_tolerances('0, '0);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_tolerances('1, '1);
          idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          set_tolerances(TOL_W'($urandom_range(200)), TOL_W'($urandom_range(2000)));
          idle_pct = 0;
          stall_pct = 68;
        end
        3: begin
          set_tolerances(TOL_W'($urandom), TOL_W'($urandom));
          idle_pct = 8;
          stall_pct = 8;
        end
        default: begin
          set_tolerances(NEAR_TOL_RST, FAR_TOL_RST);
          idle_pct = 0;
          stall_pct = 20;
          hold_req = 400;  // backs the block up until it refuses requests
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      push <= 1'b0;
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (400) @(posedge clk);

    $display("Ran %0d requests: %0d samples (%0d lost), %0d clears, %0d reports, %0d unused",
             n_sample + n_clear + n_report + n_unused, n_sample, n_lost, n_clear, n_report,
             n_unused);
    $display("%0d results compared over %0d tolerance settings, %0d field mismatches",
             sb.checked, N_PHASES + 1, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
